// ===== hdl/fmpf_pkg.sv =====
`default_nettype none
package fmpf_pkg;

  localparam int VAL_W  = 16;  // Q2.14 bin value
  localparam int X_W    = 32;  // Q16.16 position
  localparam int DX_W   = 33;
  localparam int DG_W   = 17;
  localparam int P_W    = 50;  // dx * dg
  localparam int D_W    = 51;  // denominator
  localparam int SQ_W   = 66;  // dx * dx
  localparam int T_W    = 83;  // dx * dx * dg
  localparam int N_W    = 84;  // numerator
  localparam int NMAG_W = 83;
  localparam int DMAG_W = 51;
  localparam int DIV_W  = 86;  // 2*|D| aligned to the top quotient bit
  localparam int Q_W    = 35;  // quotient bits kept, top one flags overflow
  localparam int CNT_W  = 6;
  localparam int DIFF_W = 37;

  localparam logic [CNT_W-1:0] DIV_FIRST_CNT = CNT_W'(Q_W - 1);
  localparam logic [X_W-1:0]   POS_MAX = 32'h7fff_ffff;
  localparam logic [X_W-1:0]   POS_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_DEGEN = 2'd2
  } status_t;

  typedef enum logic {
    REG_MIN_CEILING = 1'b0,
    REG_CLAMP_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic mul1;
    logic mul2;
    logic nsub;
    logic prep;
    logic div_step;
    logic fin;
    logic load_out;
  } fmpf_cmd_t;

  typedef struct packed {
    logic hit;
    logic none;
    logic dzero;
    logic div_last;
    logic out_room;
  } fmpf_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fmpf_ctrl.sv =====
`default_nettype none
module fmpf_ctrl
  import fmpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire fmpf_stat_t st,
  output fmpf_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_EVAL = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_NSUB = 9'b000010000,
    S_PREP = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_PUSH = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (st.hit)       state_nxt = S_MUL1;
        else if (st.none) state_nxt = S_PUSH;
        else              state_nxt = S_IDLE;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_NSUB;
      S_NSUB: state_nxt = S_PREP;
      S_PREP: begin
        if (st.dzero) state_nxt = S_FIN;
        else          state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.div_last) state_nxt = S_FIN;
      end
      S_FIN: state_nxt = S_PUSH;
      S_PUSH: begin
        if (st.out_room) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.accept   = in_ready && in_valid;
  assign cmd.eval     = (state_r == S_EVAL);
  assign cmd.mul1     = (state_r == S_MUL1);
  assign cmd.mul2     = (state_r == S_MUL2);
  assign cmd.nsub     = (state_r == S_NSUB);
  assign cmd.prep     = (state_r == S_PREP);
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.fin      = (state_r == S_FIN);
  assign cmd.load_out = (state_r == S_PUSH) && st.out_room;

endmodule
`default_nettype wire

// ===== hdl/fmpf_dp.sv =====
`default_nettype none
module fmpf_dp
  import fmpf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fmpf_cmd_t               cmd,
  output fmpf_stat_t                   st,
  input  wire logic [VAL_W-1:0]        min_ceiling,
  input  wire logic [VAL_W-1:0]        clamp_limit,
  input  wire logic signed [15:0]      in_re_part,
  input  wire logic signed [15:0]      in_im_part,
  input  wire logic signed [X_W-1:0]   in_bin_center,
  input  wire logic                    in_last_bin,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [X_W-1:0]        out_min_position,
  output logic [1:0]                   out_scan_status
);

  // captured beat
  logic signed [31:0]    re2_r, im2_r;
  logic [X_W-1:0]        x_in_r;
  logic                  last_r;

  // sliding window of the last three bins, oldest first
  logic [VAL_W-1:0]      rv_r [3];
  logic [X_W-1:0]        rc_r [3];
  logic [1:0]            bins_seen_r;
  logic                  scan_done_r;

  // interpolation operands and intermediates
  logic signed [X_W-1:0]    x0_r;
  logic signed [DX_W-1:0]   dx1_r, dx2_r;
  logic signed [DG_W-1:0]   dg1_r, dg2_r;
  logic signed [SQ_W-1:0]   sq1_r, sq2_r;
  logic signed [P_W-1:0]    p1_r, p2_r;
  logic signed [T_W-1:0]    t1_r, t2_r;
  logic signed [D_W-1:0]    d_r;
  logic signed [N_W-1:0]    n_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg_r;
  logic                     qneg_r;
  logic                     dzero_r;
  logic [NMAG_W-1:0]        rem_r;
  logic [DIV_W-1:0]         div_r;
  logic [Q_W-1:0]           q_r;
  logic [CNT_W-1:0]         cnt_r;

  logic [X_W-1:0]           res_pos_r;
  status_t                  res_status_r;

  logic                     out_valid_r;
  logic [X_W-1:0]           out_pos_r;
  status_t                  out_status_r;

  // bin value
  logic [31:0]       rho2;
  logic [31:0]       clamp_ext;
  logic [VAL_W-1:0]  val;
  logic              hit;
  logic              none;

  assign rho2      = {1'b0, re2_r[30:0]} + {1'b0, im2_r[30:0]};
  assign clamp_ext = {2'b00, clamp_limit, 14'd0};
  assign val       = (rho2 > clamp_ext) ? '0 : rho2[29:14];

  assign hit  = !scan_done_r && (bins_seen_r == 2'd3) && (rv_r[1] < min_ceiling) &&
                (rv_r[2] > rv_r[1]) && (val > rv_r[1]);
  assign none = !scan_done_r && last_r && !hit;

  // divider compare
  logic              div_ge;
  assign div_ge = ({{(DIV_W-NMAG_W){1'b0}}, rem_r} >= div_r);

  // final position
  logic signed [Q_W:0]       qs;
  logic signed [DIFF_W-1:0]  diff;
  logic                      diff_ovf;

  always_comb begin
    qs = qneg_r ? -$signed({2'b00, q_r[Q_W-2:0]}) : $signed({2'b00, q_r[Q_W-2:0]});
    diff = DIFF_W'(x0_r) - DIFF_W'(qs);
    diff_ovf = (diff[DIFF_W-1:X_W-1] != '0) && (diff[DIFF_W-1:X_W-1] != '1);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      re2_r  <= 32'(in_re_part) * 32'(in_re_part);
      im2_r  <= 32'(in_im_part) * 32'(in_im_part);
      x_in_r <= in_bin_center;
      last_r <= in_last_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_seen_r <= '0;
      scan_done_r <= 1'b0;
    end else if (cmd.eval) begin
      if (last_r) begin
        bins_seen_r <= '0;
        scan_done_r <= 1'b0;
      end else if (!scan_done_r) begin
        if (bins_seen_r != 2'd3) bins_seen_r <= bins_seen_r + 2'd1;
        scan_done_r <= hit;
      end
    end
  end

  // window payload is only read once three fresh bins have been shifted in
  always_ff @(posedge clk) begin
    if (cmd.eval && !scan_done_r) begin
      rv_r[0] <= rv_r[1];
      rv_r[1] <= rv_r[2];
      rv_r[2] <= val;
      rc_r[0] <= rc_r[1];
      rc_r[1] <= rc_r[2];
      rc_r[2] <= x_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && hit) begin
      x0_r  <= rc_r[1];
      dx1_r <= {rc_r[1][X_W-1], rc_r[1]} - {rc_r[0][X_W-1], rc_r[0]};
      dx2_r <= {rc_r[1][X_W-1], rc_r[1]} - {rc_r[2][X_W-1], rc_r[2]};
      dg1_r <= {1'b0, rv_r[1]} - {1'b0, rv_r[2]};
      dg2_r <= {1'b0, rv_r[1]} - {1'b0, rv_r[0]};
    end
    if (cmd.mul1) begin
      sq1_r <= SQ_W'(dx1_r) * SQ_W'(dx1_r);
      sq2_r <= SQ_W'(dx2_r) * SQ_W'(dx2_r);
      p1_r  <= P_W'(dx1_r) * P_W'(dg1_r);
      p2_r  <= P_W'(dx2_r) * P_W'(dg2_r);
    end
    if (cmd.mul2) begin
      t1_r <= T_W'(sq1_r) * T_W'(dg1_r);
      t2_r <= T_W'(sq2_r) * T_W'(dg2_r);
      d_r  <= D_W'(p1_r) - D_W'(p2_r);
    end
    if (cmd.nsub) begin
      n_r    <= N_W'(t1_r) - N_W'(t2_r);
      dneg_r <= d_r[D_W-1];
      dmag_r <= d_r[D_W-1] ? DMAG_W'(-d_r) : DMAG_W'(d_r);
    end
    if (cmd.prep) begin
      rem_r   <= n_r[N_W-1] ? NMAG_W'(-n_r) : NMAG_W'(n_r);
      div_r   <= {dmag_r, 1'b0, {(Q_W-1){1'b0}}};
      qneg_r  <= n_r[N_W-1] ^ dneg_r;
      dzero_r <= (d_r == '0);
      q_r     <= '0;
      cnt_r   <= DIV_FIRST_CNT;
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      if (div_ge) rem_r <= rem_r - div_r[NMAG_W-1:0];
      q_r   <= {q_r[Q_W-2:0], div_ge};
      div_r <= div_r >> 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && none) begin
      res_pos_r    <= '0;
      res_status_r <= STATUS_NONE;
    end else if (cmd.fin) begin
      if (dzero_r) begin
        res_pos_r    <= x0_r;
        res_status_r <= STATUS_DEGEN;
      end else begin
        res_status_r <= STATUS_FOUND;
        if (q_r[Q_W-1])   res_pos_r <= qneg_r ? POS_MAX : POS_MIN;
        else if (diff_ovf) res_pos_r <= diff[DIFF_W-1] ? POS_MIN : POS_MAX;
        else               res_pos_r <= diff[X_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_r    <= res_pos_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_position = out_pos_r;
  assign out_scan_status  = out_status_r;

  assign st.hit      = hit;
  assign st.none     = none;
  assign st.dzero    = (d_r == '0);
  assign st.div_last = (cnt_r == '0);
  assign st.out_room = !out_valid_r || out_ready;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before taken");

  a_done_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r |-> (bins_seen_r == 2'd3))
    else $error("scan marked done without a full window");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && last_r) |=> (bins_seen_r == '0 && !scan_done_r))
    else $error("scan state not cleared after last bin");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && !st.div_last) |=> cmd.div_step)
    else $error("divider stopped early");
`endif

endmodule
`default_nettype wire

// ===== hdl/first_minimum_parabolic_finder.sv =====
// a bin that gives no result frees the input once the controller goes from EVAL back to IDLE
// a no-minimum result goes from EVAL to PUSH, which waits for room, and then into the output register
// an interpolated result follows the beat of bin b+2 through EVAL, MUL1, MUL2, NSUB, PREP,
// the one-bit-per-cycle divider (skipped if the denominator is zero), FIN and PUSH
// one input beat is in flight at a time: in_ready is high only in IDLE
// reset: synchronous active-low rst_n clears the scan state, controller and output
`default_nettype none
module first_minimum_parabolic_finder
  import fmpf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_re_part,
  input  wire logic signed [15:0] in_im_part,
  input  wire logic signed [31:0] in_bin_center,
  input  wire logic               in_last_bin,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_min_position,
  output logic [1:0]              out_scan_status
);

  logic [VAL_W-1:0] min_ceiling_r;
  logic [VAL_W-1:0] clamp_limit_r;
  reg_idx_t         reg_idx;
  logic             wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ceiling_r <= 16'd16384;
      clamp_limit_r <= 16'd49152;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_CEILING: min_ceiling_r <= pwdata[VAL_W-1:0];
        REG_CLAMP_LIMIT: clamp_limit_r <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_CEILING: prdata = {16'd0, min_ceiling_r};
      REG_CLAMP_LIMIT: prdata = {16'd0, clamp_limit_r};
      default:         prdata = '0;
    endcase
  end

  fmpf_cmd_t  cmd;
  fmpf_stat_t st;

  fmpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fmpf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .min_ceiling      (min_ceiling_r),
    .clamp_limit      (clamp_limit_r),
    .in_re_part       (in_re_part),
    .in_im_part       (in_im_part),
    .in_bin_center    (in_bin_center),
    .in_last_bin      (in_last_bin),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_position (out_min_position),
    .out_scan_status  (out_scan_status)
  );

endmodule
`default_nettype wire
